// ----- src/edf_ready_table_scheduler_top_macros.svh -----
// assertion macros for the scheduler top level
`ifndef EDF_READY_TABLE_SCHEDULER_TOP_MACROS_SVH
`define EDF_READY_TABLE_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define EDF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, checked outside reset
`define EDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ----- src/edf_pkg.sv -----
package edf_pkg;

  localparam int JOB_W   = 16;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 24;
  localparam int SLACK_W = 26;

  localparam logic [TIME_W-1:0]         TIME_MAX  = {TIME_W{1'b1}};
  localparam logic signed [SLACK_W-1:0] SLACK_MIN = {1'b1, {(SLACK_W-1){1'b0}}};

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [2:0] OC_IDLE   = 3'd0;
  localparam logic [2:0] OC_RAN    = 3'd1;
  localparam logic [2:0] OC_FINISH = 3'd2;
  localparam logic [2:0] OC_ACCEPT = 3'd3;
  localparam logic [2:0] OC_REJECT = 3'd4;

  typedef struct packed {
    logic [JOB_W-1:0]          job;
    logic [BURST_W-1:0]        burst;
    logic [TIME_W-1:0]         due;
    logic signed [SLACK_W-1:0] slack;
  } entry_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [JOB_W-1:0]   job;
    logic [TIME_W-1:0]  tstamp;
    logic [BURST_W-1:0] left;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } state_t;

endpackage

// ----- src/edf_entry_ram.sv -----
module edf_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  edf_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output edf_pkg::entry_t rdata
);
  import edf_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/edf_ctrl.sv -----
module edf_ctrl #(
  parameter int READY_SLOTS = 16,
  parameter int IDX_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          req_type,
  input  logic [edf_pkg::JOB_W-1:0]     job_id,
  input  logic [edf_pkg::BURST_W-1:0]   burst_len,
  input  logic [edf_pkg::TIME_W-1:0]    due_time,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output edf_pkg::entry_t               mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  edf_pkg::entry_t               mem_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output edf_pkg::result_t              res
);
  import edf_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(READY_SLOTS - 1);

  state_t state, state_next;

  logic [READY_SLOTS-1:0] slot_valid;
  logic [READY_SLOTS-1:0] slot_pend;
  logic [TIME_W-1:0]      now_time;

  logic [JOB_W-1:0]   req_job;
  logic [BURST_W-1:0] req_burst;
  logic [TIME_W-1:0]  req_due;

  logic [IDX_W-1:0] idx;
  logic             rd_on;
  logic             cmp_on;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  entry_t           best;
  logic [IDX_W-1:0] best_idx;

  entry_t                    eff;
  entry_t                    new_entry;
  logic                      better;
  logic signed [SLACK_W-1:0] arr_slack;

  // entry a goes ahead of entry b
  function automatic logic goes_first(entry_t a, entry_t b);
    logic r;
    if (a.due != b.due) begin
      r = a.due < b.due;
    end else if (a.burst != b.burst) begin
      r = a.burst < b.burst;
    end else begin
      r = a.slack < b.slack;
    end
    return r;
  endfunction

  always_comb begin
    // apply the pending decrement from the last run tick
    eff = mem_rdata;
    if (slot_pend[cmp_idx] && (mem_rdata.slack != SLACK_MIN)) begin
      eff.slack = mem_rdata.slack - SLACK_W'(1);
    end
    better = !found || goes_first(eff, best);

    arr_slack = $signed({2'b00, req_due}) - $signed({10'b0, req_burst})
              - $signed({2'b00, now_time});
    new_entry.job   = req_job;
    new_entry.burst = req_burst;
    new_entry.due   = req_due;
    new_entry.slack = arr_slack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = new_entry;
    mem_re     = 1'b0;
    mem_raddr  = idx;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = (req_type == REQ_ARRIVAL) ? ST_ARR : ST_SCAN;
        end
      end
      ST_ARR: begin
        if (!slot_valid[idx]) begin
          mem_we     = 1'b1;
          state_next = ST_DONE;
        end else if (idx == LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        mem_re = rd_on;
        if (cmp_on) begin
          mem_we    = slot_valid[cmp_idx];
          mem_waddr = cmp_idx;
          mem_wdata = eff;
          if (cmp_idx == LAST) begin
            state_next = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        mem_waddr       = best_idx;
        mem_wdata       = best;
        mem_wdata.burst = best.burst - BURST_W'(1);
        mem_we          = found && (best.burst != '0);
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_pend  <= '0;
      now_time   <= '0;
      rd_on      <= 1'b0;
      cmp_on     <= 1'b0;
      found      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            idx   <= '0;
            rd_on <= (req_type == REQ_TICK);
            found <= 1'b0;
          end
        end
        ST_ARR: begin
          if (!slot_valid[idx]) begin
            slot_valid[idx] <= 1'b1;
            slot_pend[idx]  <= 1'b0;
          end else if (idx != LAST) begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_SCAN: begin
          cmp_on <= rd_on;
          if (rd_on) begin
            if (idx == LAST) begin
              rd_on <= 1'b0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
          if (cmp_on) begin
            slot_pend[cmp_idx] <= 1'b0;
            if (slot_valid[cmp_idx] && better) begin
              found <= 1'b1;
            end
          end
        end
        ST_PICK: begin
          if (now_time != TIME_MAX) begin
            now_time <= now_time + TIME_W'(1);
          end
          if (found) begin
            if (best.burst == '0) begin
              slot_valid[best_idx] <= 1'b0;
            end else begin
              // every live entry loses one unit of slack, applied on the next scan
              slot_pend <= slot_valid;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_job   <= job_id;
          req_burst <= burst_len;
          req_due   <= due_time;
        end
      end
      ST_ARR: begin
        res.job    <= req_job;
        res.tstamp <= now_time;
        if (!slot_valid[idx]) begin
          res.outcome <= OC_ACCEPT;
          res.left    <= req_burst;
        end else begin
          res.outcome <= OC_REJECT;
          res.left    <= '0;
        end
      end
      ST_SCAN: begin
        cmp_idx <= idx;
        if (cmp_on && slot_valid[cmp_idx] && better) begin
          best     <= eff;
          best_idx <= cmp_idx;
        end
      end
      ST_PICK: begin
        res.tstamp <= now_time;
        if (!found) begin
          res.outcome <= OC_IDLE;
          res.job     <= '0;
          res.left    <= '0;
        end else if (best.burst == '0) begin
          res.outcome <= OC_FINISH;
          res.job     <= best.job;
          res.left    <= '0;
        end else begin
          res.outcome <= OC_RAN;
          res.job     <= best.job;
          res.left    <= best.burst - BURST_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/edf_ready_table_scheduler_top.sv -----
// channel   signals                                       beat when
// request   req_valid req_ready req_type job_id           req_valid && req_ready
//           burst_len due_time
// response  rsp_valid rsp_ready outcome out_job           rsp_valid && rsp_ready
//           out_time left_burst
//
// a tick does one read a cycle from the entry ram, then a trailing compare,
// the pick and the hand-off to the response register
// an arrival walks up from slot 0 to the first free slot, or rejects at the last
// a new request is taken while the previous response still waits for rsp_ready
// rst is synchronous, active high; it clears valid and pending bits and time
// entry ram contents need no clearing: a slot's data is only used while valid
module edf_ready_table_scheduler_top #(
  parameter int READY_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        req_type,
  input  logic [edf_pkg::JOB_W-1:0]   job_id,
  input  logic [edf_pkg::BURST_W-1:0] burst_len,
  input  logic [edf_pkg::TIME_W-1:0]  due_time,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [2:0]                  outcome,
  output logic [edf_pkg::JOB_W-1:0]   out_job,
  output logic [edf_pkg::TIME_W-1:0]  out_time,
  output logic [edf_pkg::BURST_W-1:0] left_burst
);
  import edf_pkg::*;

`include "edf_ready_table_scheduler_top_macros.svh"

  // slot index width, at least one bit
  localparam int IDX_W = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;

  // entry ram ports
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // finished result from the controller
  logic    res_valid;
  logic    res_ready;
  result_t res;

  edf_entry_ram #(
    .DEPTH (READY_SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  edf_ctrl #(
    .READY_SLOTS (READY_SLOTS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .job_id    (job_id),
    .burst_len (burst_len),
    .due_time  (due_time),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // response register: loads when empty or when its beat leaves this cycle
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      outcome    <= res.outcome;
      out_job    <= res.job;
      out_time   <= res.tstamp;
      left_burst <= res.left;
    end
  end

  // the controller takes one request at a time
  `EDF_ASSERT_NEXT(a_one_req, req_valid && req_ready, !req_ready)
  // a handed-off result always shows up on the response side
  `EDF_ASSERT_NEXT(a_res_lands, res_valid && res_ready, rsp_valid)
  // an idle tick carries no job and no burst
  `EDF_ASSERT_NOW(a_idle_tick, rsp_valid && (outcome == OC_IDLE),
                  (out_job == '0) && (left_burst == '0))

endmodule

// ----- sim/edf_ready_table_scheduler_checker.sv -----
`timescale 1ns / 100ps

module edf_ready_table_scheduler_checker #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  logic                        req_type,
  input  logic [edf_pkg::JOB_W-1:0]   job_id,
  input  logic [edf_pkg::BURST_W-1:0] burst_len,
  input  logic [edf_pkg::TIME_W-1:0]  due_time,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  logic [2:0]                  outcome,
  input  logic [edf_pkg::JOB_W-1:0]   out_job,
  input  logic [edf_pkg::TIME_W-1:0]  out_time,
  input  logic [edf_pkg::BURST_W-1:0] left_burst,
  output int                          fail_count,
  output int                          outstanding,
  output int                          req_beats,
  output int                          accept_cnt,
  output int                          reject_cnt,
  output int                          finish_cnt,
  output int                          idle_cnt
);
  import edf_pkg::*;

  // shadow copy of the ready table
  logic                      occupied  [SLOTS];
  logic [JOB_W-1:0]          slot_ids  [SLOTS];
  logic [BURST_W-1:0]        remaining [SLOTS];
  logic [TIME_W-1:0]         deadlines [SLOTS];
  logic signed [SLACK_W-1:0] slack_of  [SLOTS];
  logic [TIME_W-1:0]         sched_now;

  result_t predicted_outcomes[$];

  // edf order: deadline, then remaining burst, then slack; ties keep the lower slot
  function automatic bit runs_before(int a, int b);
    if (deadlines[a] != deadlines[b]) return deadlines[a] < deadlines[b];
    if (remaining[a] != remaining[b]) return remaining[a] < remaining[b];
    return slack_of[a] < slack_of[b];
  endfunction

  function automatic result_t schedule_request(logic kind, logic [JOB_W-1:0] job,
                                               logic [BURST_W-1:0] burst,
                                               logic [TIME_W-1:0] due);
    result_t r;
    int      slot;
    bit      found;
    int      s;
    r = '0;
    r.tstamp = sched_now;
    if (kind == REQ_ARRIVAL) begin
      slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!occupied[i] && slot < 0) slot = i;
      end
      r.job = job;
      if (slot < 0) begin
        r.outcome = OC_REJECT;
      end else begin
        s = int'(due) - int'(burst) - int'(sched_now);
        occupied[slot]  = 1'b1;
        slot_ids[slot]  = job;
        remaining[slot] = burst;
        deadlines[slot] = due;
        slack_of[slot]  = s[SLACK_W-1:0];
        r.outcome = OC_ACCEPT;
        r.left    = burst;
      end
    end else begin
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (occupied[i] && (!found || runs_before(i, slot))) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (sched_now != TIME_MAX) sched_now = sched_now + 1'b1;
      if (!found) begin
        r.outcome = OC_IDLE;
      end else if (remaining[slot] == '0) begin
        occupied[slot] = 1'b0;
        r.outcome = OC_FINISH;
        r.job     = slot_ids[slot];
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (occupied[i] && slack_of[i] != SLACK_MIN) slack_of[i] = slack_of[i] - 1'b1;
        end
        remaining[slot] = remaining[slot] - 1'b1;
        r.outcome = OC_RAN;
        r.job     = slot_ids[slot];
        r.left    = remaining[slot];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t predicted;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
      sched_now = '0;
      predicted_outcomes.delete();
      fail_count  = 0;
      outstanding = 0;
      req_beats   = 0;
      accept_cnt  = 0;
      reject_cnt  = 0;
      finish_cnt  = 0;
      idle_cnt    = 0;
    end else begin
      // response first: a beat here always belongs to an earlier request
      if (rsp_valid && rsp_ready) begin
        if (predicted_outcomes.size() == 0) begin
          $error("response beat with nothing expected: outcome %0d out_job %h", outcome,
                 out_job);
          fail_count++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (outcome !== want.outcome) begin
            $error("outcome mismatch: expected %0d, actual %0d", want.outcome, outcome);
            fail_count++;
          end
          if (out_job !== want.job) begin
            $error("out_job mismatch: expected %h, actual %h", want.job, out_job);
            fail_count++;
          end
          if (out_time !== want.tstamp) begin
            $error("out_time mismatch: expected %h, actual %h", want.tstamp, out_time);
            fail_count++;
          end
          if (left_burst !== want.left) begin
            $error("left_burst mismatch: expected %h, actual %h", want.left, left_burst);
            fail_count++;
          end
          case (want.outcome)
            OC_ACCEPT: accept_cnt++;
            OC_REJECT: reject_cnt++;
            OC_FINISH: finish_cnt++;
            OC_IDLE:   idle_cnt++;
            default: ;
          endcase
        end
      end
      if (req_valid && req_ready) begin
        predicted = schedule_request(req_type, job_id, burst_len, due_time);
        predicted_outcomes = {predicted_outcomes, predicted};
        req_beats++;
      end
      outstanding = predicted_outcomes.size();
    end
  end

endmodule

// ----- sim/edf_ready_table_scheduler_top_tb.sv -----
`timescale 1ns / 100ps

module edf_ready_table_scheduler_top_tb;
  import edf_pkg::*;

  localparam int SLOTS         = 16;
  localparam int RANDOM_ITEMS  = 1625;
  // longest correct quiet stretch is the response hold-off below
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_AT_BEAT  = 240;
  localparam int HOLD_CYCLES   = 600;
  // a tick walks every slot, then does the pick and the hand-off
  localparam int SETTLE_CYCLES = 4 * (SLOTS + 4);

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic               req_type;
  logic [JOB_W-1:0]   job_id;
  logic [BURST_W-1:0] burst_len;
  logic [TIME_W-1:0]  due_time;
  logic               rsp_valid;
  logic               rsp_ready;
  logic [2:0]         outcome;
  logic [JOB_W-1:0]   out_job;
  logic [TIME_W-1:0]  out_time;
  logic [BURST_W-1:0] left_burst;

  int fail_count;
  int outstanding;
  int req_beats;
  int accept_cnt;
  int reject_cnt;
  int finish_cnt;
  int idle_cnt;

  // ticks handed to the block so far; equals the block's time, which never saturates here
  int ticks_sent;
  // back-to-back mode for the request side, redrawn per episode
  bit req_fast;
  bit rsp_fast;

  edf_ready_table_scheduler_top #(
    .READY_SLOTS(SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .job_id     (job_id),
    .burst_len  (burst_len),
    .due_time   (due_time),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .outcome    (outcome),
    .out_job    (out_job),
    .out_time   (out_time),
    .left_burst (left_burst)
  );

  // predicts every request beat and compares every response beat
  edf_ready_table_scheduler_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_type    (req_type),
    .job_id      (job_id),
    .burst_len   (burst_len),
    .due_time    (due_time),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .outcome     (outcome),
    .out_job     (out_job),
    .out_time    (out_time),
    .left_burst  (left_burst),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .req_beats   (req_beats),
    .accept_cnt  (accept_cnt),
    .reject_cnt  (reject_cnt),
    .finish_cnt  (finish_cnt),
    .idle_cnt    (idle_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one request beat; entered and left at a falling edge
  // valid stays high across back-to-back beats, so only one assignment per edge
  task automatic send_req(input logic kind, input logic [JOB_W-1:0] job,
                          input logic [BURST_W-1:0] burst, input logic [TIME_W-1:0] due);
    int unsigned gap;
    gap = req_fast ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    job_id    <= job;
    burst_len <= burst;
    due_time  <= due;
    do @(posedge clk); while (!req_ready);
    if (kind == REQ_TICK) ticks_sent++;
    @(negedge clk);
  endtask

  // job fields on a tick are ignored by the block, so they carry noise
  task automatic send_tick();
    send_req(REQ_TICK, 16'($urandom()), 16'($urandom()), 24'($urandom()));
  endtask

  // mostly short bursts with deadlines close to now, so jobs finish and ties happen;
  // some deadlines already passed (negative slack) and some far out
  task automatic send_arrival();
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  due;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) burst = '0;
    else if (pick < 90) burst = 16'($urandom_range(1, 4));
    else burst = 16'($urandom_range(5, 20));
    pick = $urandom_range(0, 99);
    if (pick < 70) due = 24'(ticks_sent) + 24'($urandom_range(0, 40));
    else if (pick < 85) due = (ticks_sent > 8) ? 24'(ticks_sent) - 24'($urandom_range(0, 8))
                                               : '0;
    else due = 24'($urandom());
    send_req(REQ_ARRIVAL, 16'($urandom()), burst, due);
  endtask

  // response side: a random wait before each beat, stretches with none,
  // and one long hold-off so the table side backs up into req_ready
  initial begin : rsp_side
    int unsigned gap;
    int          beats;
    rsp_ready = 1'b0;
    rsp_fast  = 1'b0;
    gap       = 0;
    beats     = 0;
    forever begin
      @(negedge clk);
      if (rst || gap > 0) begin
        rsp_ready <= 1'b0;
        if (!rst) gap--;
      end else begin
        rsp_ready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        beats++;
        if (beats % 50 == 0) rsp_fast = ($urandom_range(0, 2) == 0);
        if (beats == HOLD_AT_BEAT) gap = HOLD_CYCLES;
        else if (rsp_fast) gap = 0;
        else gap = $urandom_range(0, 16);
      end
    end
  end

  // ends the run if no beat moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("edf_ready_table_scheduler_top_tb failed");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int mode;
    int arr_pct;
    int ep_len;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = REQ_ARRIVAL;
    job_id     = '0;
    burst_len  = '0;
    due_time   = '0;
    ticks_sent = 0;
    req_fast   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, deadline/burst/slack tie-breaks, full table
    send_tick();                                             // idle tick on empty table
    send_req(REQ_ARRIVAL, 16'h1235, 16'h0003, 24'h000005);   // slot 0
    send_req(REQ_ARRIVAL, 16'h1236, 16'h0003, 24'h000005);   // full tie with slot 0
    send_req(REQ_ARRIVAL, 16'h0000, 16'h0000, 24'h000000);   // zeros, deadline passed
    send_req(REQ_ARRIVAL, 16'hffff, 16'h0002, 24'hffffff);   // latest deadline, waits
    send_req(REQ_ARRIVAL, 16'h1234, 16'h0001, 24'h000005);   // same deadline, shorter burst
    send_tick();                                             // zero burst finishes, no run
    send_req(REQ_ARRIVAL, 16'h1237, 16'h0003, 24'h000005);   // refills slot 2, less slack
    send_tick();                                             // shorter burst wins
    send_tick();                                             // that job finishes
    send_tick();                                             // less slack beats lower slots
    // twelve free slots left: fill them, then offer extremes to a full table
    for (int k = 0; k < 12; k++) begin
      send_req(REQ_ARRIVAL, 16'h0100 + 16'(k), 16'(k % 3), 24'h000010 + 24'(k));
    end
    send_req(REQ_ARRIVAL, 16'hffff, 16'hffff, 24'hffffff);
    send_req(REQ_ARRIVAL, 16'h5a5a, 16'hffff, 24'h000000);

    // random episodes: mixed traffic, fill-to-reject, and drain
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode     = $urandom_range(0, 9);
      req_fast = ($urandom_range(0, 3) == 0);
      if (mode >= 8) begin
        // table is certainly full after this many arrivals with no tick between
        repeat (SLOTS) begin
          send_arrival();
          sent++;
        end
        // rejected beats leave the table alone, so any field value is safe here
        repeat ($urandom_range(1, 4)) begin
          send_req(REQ_ARRIVAL, 16'($urandom()), 16'($urandom()), 24'($urandom()));
          sent++;
        end
      end else begin
        arr_pct = (mode < 5) ? 25 : 6;
        ep_len  = $urandom_range(16, 48);
        repeat (ep_len) begin
          if ($urandom_range(0, 99) < arr_pct) send_arrival();
          else send_tick();
          sent++;
        end
      end
    end
    req_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d requests over %0d ticks: %0d accepted, %0d rejected on a full table,",
             req_beats, ticks_sent, accept_cnt, reject_cnt);
    $display("%0d jobs finished, %0d idle ticks, with a %0d-cycle response hold-off",
             finish_cnt, idle_cnt, HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("edf_ready_table_scheduler_top_tb passed");
    end else begin
      $display("edf_ready_table_scheduler_top_tb failed");
    end
    $finish;
  end

endmodule
